### src/dde12_pkg.sv
// Shared types and constants for the 12-bit DPCM delta encoder.
package dde12_pkg;

   // Saturation limits of the difference, 13-bit two's complement
   localparam logic signed [16:0] DIFF_CEIL  = 17'sd4094;
   localparam logic signed [16:0] DIFF_FLOOR = -17'sd4096;

   // Bytes produced by one request: first always, second when two_bytes
   typedef struct packed {
      logic       two_bytes;
      logic [7:0] first;
      logic [7:0] second;
   } pack_type;

endpackage

### src/dpcm_delta_encoder_12bit_core.sv
// Top level of the 12-bit DPCM delta encoder with byte output queue.
//
// Usage: each request on req_ carries one signed 16-bit PCM sample. The
// block subtracts its prediction, saturates the difference to
// -4096..4094 and packs bits 12..1 as a 12-bit code, two codes per three
// bytes. Bytes leave on rsp_ one per cycle while rsp_ready is high;
// rsp_last marks the final byte caused by a sample. One byte is always
// held back inside the block; there is no flush.
// The first byte of a sample is on rsp_ in the cycle after the request
// is taken. A sample that yields one byte can be taken every cycle while
// rsp_ready is high; after one that yields two bytes, the next waits
// until its second byte heads the queue; the single byte-wide port sets this.
// A two-entry byte queue sits in front of rsp_, so a new request is
// taken in the same cycle the last queued byte is taken.
// Reset (synchronous, active high) clears prediction, phase, pending
// byte and the queue. When the receiver stalls, queued bytes hold and
// req_ready drops once the queue cannot take a new sample's bytes.
module dpcm_delta_encoder_12bit_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last
);
   import dde12_pkg::*;

   pack_type   pack;
   logic       take;
   logic       a_vld_ff, a_vld_in;
   logic [7:0] a_byte_ff, a_byte_in;
   logic       a_last_ff, a_last_in;
   logic       b_vld_ff, b_vld_in;
   logic [7:0] b_byte_ff, b_byte_in;
   logic       b_last_ff, b_last_in;

   // Accept when the spill slot is empty and the head is empty or frees this cycle
   assign req_ready = !b_vld_ff && (!a_vld_ff || rsp_ready);
   assign take      = req_valid && req_ready;

   dde12_codec u_codec (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .sample (req_sample),
      .pack   (pack)
   );

   // Advance the queue: drop the taken byte, move spill up, load request
   always_comb begin
      a_vld_in  = a_vld_ff;
      a_byte_in = a_byte_ff;
      a_last_in = a_last_ff;
      b_vld_in  = b_vld_ff;
      b_byte_in = b_byte_ff;
      b_last_in = b_last_ff;
      if (a_vld_ff && rsp_ready) begin
         a_vld_in = 1'b0;
         if (b_vld_ff) begin
            a_vld_in  = 1'b1;
            a_byte_in = b_byte_ff;
            a_last_in = b_last_ff;
            b_vld_in  = 1'b0;
         end
      end
      if (take) begin
         a_vld_in  = 1'b1;
         a_byte_in = pack.first;
         a_last_in = !pack.two_bytes;
         b_vld_in  = pack.two_bytes;
         b_byte_in = pack.second;
         b_last_in = 1'b1;
      end
   end

   // Clear queue control under reset; payload needs none
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
      end
      a_byte_ff <= a_byte_in;
      a_last_ff <= a_last_in;
      b_byte_ff <= b_byte_in;
      b_last_ff <= b_last_in;
   end

   assign rsp_valid    = a_vld_ff;
   assign rsp_out_byte = a_byte_ff;
   assign rsp_last     = a_last_ff;

   a_spill_order: assert property (@(posedge clock) disable iff (reset)
      b_vld_ff |-> a_vld_ff && !a_last_ff && b_last_ff)
      else $error("spill byte without matching head byte");
   a_take_shows: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid)
      else $error("request taken but no byte presented");
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid && rsp_last)
      else $error("second byte of pair missing");

endmodule

### src/dde12_codec.sv
// Prediction, saturation and 12-bit code packing state of the encoder.
module dde12_codec (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic signed [15:0]  sample,
   output dde12_pkg::pack_type pack
);
   import dde12_pkg::*;

   logic [15:0]        prediction_ff, prediction_in;
   logic               odd_ff, odd_in;
   logic [7:0]         pend_ff, pend_in;
   logic               pend_vld_ff, pend_vld_in;
   logic signed [16:0] diff;
   logic signed [16:0] sat;
   logic [12:0]        code;

   // Difference from prediction, saturated to the 13-bit code range
   always_comb begin
      diff = 17'(sample) - 17'(signed'(prediction_ff));
      priority if (diff > DIFF_CEIL) begin
         sat = DIFF_CEIL;
      end else if (diff < DIFF_FLOOR) begin
         sat = DIFF_FLOOR;
      end else begin
         sat = diff;
      end
      code = sat[12:0];
   end

   // Pack code bits 12..1 and advance the state
   always_comb begin
      pack          = '0;
      prediction_in = prediction_ff
                      + {{3{code[12]}}, code[12:1], 1'b0};
      odd_in        = !odd_ff;
      pend_vld_in   = 1'b1;
      if (!odd_ff) begin
         pack.two_bytes = pend_vld_ff;
         pack.first     = pend_vld_ff ? pend_ff : code[12:5];
         pack.second    = code[12:5];
         pend_in        = {code[4:1], 4'h0};
      end else begin
         pack.two_bytes = 1'b0;
         pack.first     = pend_ff | {4'h0, code[12:9]};
         pack.second    = code[12:5];
         pend_in        = code[8:1];
      end
   end

   // Hold state until a request is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         prediction_ff <= '0;
         odd_ff        <= 1'b0;
         pend_ff       <= '0;
         pend_vld_ff   <= 1'b0;
      end else if (take) begin
         prediction_ff <= prediction_in;
         odd_ff        <= odd_in;
         pend_ff       <= pend_in;
         pend_vld_ff   <= pend_vld_in;
      end
   end

   a_phase_flips: assert property (@(posedge clock) disable iff (reset)
      take |=> odd_ff != $past(odd_ff))
      else $error("phase did not toggle on request");
   a_pend_set: assert property (@(posedge clock) disable iff (reset)
      take |=> pend_vld_ff)
      else $error("pending byte not marked after request");
   a_pred_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(prediction_ff))
      else $error("prediction changed without request");

endmodule

### sim/dde12_stream_check.sv
// Stream checker for the 12-bit DPCM delta encoder: predicts and compares output bytes.
`timescale 1ns / 100ps

module dde12_stream_check (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_sample,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [7:0]         rsp_out_byte,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 bytes_open,
   output int                 bytes_checked,
   output int                 samples_taken,
   output int                 clipped_count
);
   import dde12_pkg::*;

   // One expected output byte and its end-of-sample flag
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } coded_byte_type;

   // Encoder state mirrored from the block
   logic [15:0]    pred_level;
   logic           odd_code;
   logic [7:0]     held_byte;
   logic           held_valid;
   coded_byte_type expected_bytes[$];

   int fails = 0;
   int checked = 0;
   int taken = 0;
   int clipped = 0;

   assign fail_count    = fails;
   assign bytes_checked = checked;
   assign samples_taken = taken;
   assign clipped_count = clipped;

   initial bytes_open = 0;

   // Encode one sample: saturate the difference, pack the 12-bit code, advance prediction
   task automatic encode_sample(input logic signed [15:0] sample);
      logic signed [16:0] diff;
      coded_byte_type     cb;
      diff = $signed({sample[15], sample}) - $signed({pred_level[15], pred_level});
      if (diff > DIFF_CEIL) begin
         diff = DIFF_CEIL;
         clipped++;
      end else if (diff < DIFF_FLOOR) begin
         diff = DIFF_FLOOR;
         clipped++;
      end
      if (!odd_code) begin
         // first code of a pair: flush the held byte, emit bits 12..5, hold bits 4..1
         if (held_valid) begin
            cb.out_byte = held_byte;
            cb.last     = 1'b0;
            expected_bytes.insert(expected_bytes.size(), cb);
         end
         cb.out_byte = diff[12:5];
         cb.last     = 1'b1;
         expected_bytes.insert(expected_bytes.size(), cb);
         held_byte = {diff[4:1], 4'h0};
      end else begin
         // second code: merge bits 12..9 into the held byte, hold bits 8..1
         cb.out_byte = held_byte | {4'h0, diff[12:9]};
         cb.last     = 1'b1;
         expected_bytes.insert(expected_bytes.size(), cb);
         held_byte = diff[8:1];
      end
      held_valid = 1'b1;
      pred_level = pred_level + {diff[15:1], 1'b0};
      odd_code   = ~odd_code;
   endtask

   // Compare each taken byte with the oldest prediction, then encode each taken request
   always @(posedge clock) begin
      coded_byte_type want;
      if (reset) begin
         pred_level = 16'h0000;
         odd_code   = 1'b0;
         held_byte  = 8'h00;
         held_valid = 1'b0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_bytes.size() == 0) begin
               $error("unexpected byte: out_byte %02h last %0b", rsp_out_byte, rsp_last);
               fails++;
            end else begin
               want = expected_bytes[0];
               expected_bytes.delete(0);
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte mismatch: expected %02h, actual %02h",
                         want.out_byte, rsp_out_byte);
                  fails++;
               end
               if (rsp_last !== want.last) begin
                  $error("last mismatch: expected %0b, actual %0b", want.last, rsp_last);
                  fails++;
               end
            end
         end
         if (req_valid && req_ready) begin
            encode_sample(req_sample);
            taken++;
         end
      end
      bytes_open <= expected_bytes.size();
   end

endmodule

### sim/dpcm_delta_encoder_12bit_core_test.sv
// Testbench top for the 12-bit DPCM delta encoder: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module dpcm_delta_encoder_12bit_core_test;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_SAMPLES = 450;
   localparam int PRESSURE_AT    = 400;
   localparam int PRESSURE_LEN   = 120;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_sample = 16'sh0000;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_out_byte;
   logic               rsp_last;

   int fail_count;
   int bytes_open;
   int bytes_checked;
   int samples_taken;
   int clipped_count;
   int cycle_count = 0;
   int sender_calm_left = 0;

   // Extremes, saturation both ways, a climb to full scale and small steps around zero
   logic signed [15:0] corner_samples [24] = '{
      16'sh0000, 16'sh0001, 16'shFFFF, 16'sh0FFE, 16'sh1FFF, 16'sh7FFF,
      16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
      16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8001,
      16'shF000, 16'shEFFF, 16'sh0000, 16'sh5555, 16'shAAAA, 16'sh0003
   };

   dpcm_delta_encoder_12bit_core u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   dde12_stream_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last),
      .fail_count    (fail_count),
      .bytes_open    (bytes_open),
      .bytes_checked (bytes_checked),
      .samples_taken (samples_taken),
      .clipped_count (clipped_count)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hold reset from the start, then release it once
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Stop a hung run
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("dpcm_delta_encoder_12bit_core_test: errors");
            $finish;
         end
      end
   end

   // Offer one request after an optional random gap and hold it until taken
   task automatic send_sample(input logic signed [15:0] sample);
      int gap;
      int pick;
      gap = 0;
      if (sender_calm_left > 0) begin
         sender_calm_left--;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            sender_calm_left = $urandom_range(10, 40);
         end else if (pick < 8) begin
            gap = $urandom_range(10, 40);
         end else if (pick < 40) begin
            gap = $urandom_range(1, 3);
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= sample;
      do @(posedge clock); while (!req_ready);
   endtask

   // Receiver: short and long stalls, calm stretches, and one long hold-off
   initial begin
      int   hold_left;
      int   calm_left;
      int   since_reset;
      int   pick;
      logic ready_next;
      hold_left   = 0;
      calm_left   = 0;
      since_reset = 0;
      while (reset) @(posedge clock);
      forever begin
         since_reset++;
         if (since_reset == PRESSURE_AT) begin
            hold_left = PRESSURE_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            ready_next = 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               calm_left  = $urandom_range(20, 60);
               ready_next = 1'b1;
            end else if (pick < 8) begin
               hold_left  = $urandom_range(10, 30);
               ready_next = 1'b0;
            end else if (pick < 30) begin
               hold_left  = $urandom_range(0, 3);
               ready_next = 1'b0;
            end else begin
               ready_next = 1'b1;
            end
         end
         rsp_ready <= ready_next;
         @(posedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      int walk;
      int pick;
      walk = 0;
      while (reset) @(posedge clock);

      // directed corners
      foreach (corner_samples[i]) begin
         send_sample(corner_samples[i]);
      end

      // audio-like walks with steps near the clip limit, tiny steps and full-range jumps
      for (int n = 0; n < RANDOM_SAMPLES; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            walk = walk + $urandom_range(0, 8400) - 4200;
         end else if (pick < 75) begin
            walk = walk + $urandom_range(0, 16) - 8;
         end else begin
            walk = $urandom_range(0, 65535) - 32768;
         end
         if (walk > 32767) begin
            walk = 32767;
         end else if (walk < -32768) begin
            walk = -32768;
         end
         send_sample(16'(walk));
      end
      req_valid <= 1'b0;

      // drain the predicted bytes, then let the outputs settle before the verdict
      @(posedge clock);
      while (bytes_open != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("run covered %0d samples, %0d bytes compared, %0d clipped differences",
               samples_taken, bytes_checked, clipped_count);
      $display("one byte stays held inside the encoder by design");
      if (fail_count == 0) begin
         $display("dpcm_delta_encoder_12bit_core_test: clean");
      end else begin
         $display("dpcm_delta_encoder_12bit_core_test: errors");
      end
      $finish;
   end

endmodule

### filelist.f
src/dde12_pkg.sv
src/dde12_codec.sv
src/dpcm_delta_encoder_12bit_core.sv
sim/dde12_stream_check.sv
sim/dpcm_delta_encoder_12bit_core_test.sv
